// ===== src/ics_pkg.sv =====
// ---------------------------------------------------------------------------
// ics_pkg: shared types and constants of the inversion counting sorter
// Field widths, default parameter values and the per-cell control bundle.
// ---------------------------------------------------------------------------
package ics_pkg;

    localparam int DATA_BITS      = 32;
    localparam int INV_BITS       = 9;
    localparam int IN_TDATA_BITS  = 32;
    localparam int OUT_TDATA_BITS = 48;

    localparam int DEF_MAX_ITEMS  = 32;
    localparam int DEF_VALUE_BITS = 32;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic ins;    // insert the new value this cycle
        logic shift;  // move every value one cell toward the output
    } t_cell_ctl;

endpackage

// ===== src/inversion_count_sorter.sv =====
// ---------------------------------------------------------------------------
// inversion_count_sorter: stable insertion sorter with inversion count
// Collects a list, keeps it sorted in a chain of cells and counts inversions.
// ---------------------------------------------------------------------------
// usage:
//   slave channel: one signed value per transfer in tdata[31:0], tlast on the
//   final value of a list. values are taken one per cycle while filling.
//   master channel: after the final value the list leaves in ascending stable
//   order, one result per cycle unless stalled, tdata = {pad, inversions[8:0], value[31:0]},
//   tuser = dropped, tlast on the last result of the list.
//   drain: after the final input transfer the value is inserted and the ST_SUM
//   state finishes the count, then fill_count results leave, one per cycle
//   while the receiver is ready. the drain is set by the chain shifting one cell
//   per output transfer. tready on the slave side stays low during the drain.
//   values beyond MAX_ITEMS are discarded and set the dropped flag.
//   the receiver may stall at any time; the chain simply holds its contents.
//   reset empties the chain and clears the count and the dropped flag; the
//   same happens after the last result of each list.
// ---------------------------------------------------------------------------
module inversion_count_sorter #(
    parameter int MAX_ITEMS  = ics_pkg::DEF_MAX_ITEMS,
    parameter int VALUE_BITS = ics_pkg::DEF_VALUE_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [ics_pkg::IN_TDATA_BITS-1:0]  i_s_axis_tdata,  // value[31:0]
    input  logic                               i_s_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [ics_pkg::OUT_TDATA_BITS-1:0] o_m_axis_tdata,  // value[31:0], inversions[40:32]
    output logic                               o_m_axis_tuser,  // dropped
    output logic                               o_m_axis_tlast
);

    localparam int FW  = $clog2(MAX_ITEMS + 1);
    localparam int PW  = $clog2(MAX_ITEMS);
    localparam int IB  = ics_pkg::INV_BITS;
    localparam int SW  = ((IB > FW) ? IB : FW) + 1;
    localparam int DB  = ics_pkg::DATA_BITS;
    localparam int PAD = ics_pkg::OUT_TDATA_BITS - DB - IB;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_SUM,
        ST_DRAIN
    } t_state;

    t_state         r_state;
    logic [FW-1:0]  r_fill;
    logic [IB-1:0]  r_total;
    logic           r_drop;
    logic           r_add_vld;
    logic [MAX_ITEMS-1:0] r_bnd;
    logic [FW-1:0]  r_fill_at;

    logic                  in_xfer;
    logic                  out_xfer;
    logic                  full;
    logic                  do_ins;
    logic [63:0]           in_ext;
    logic [VALUE_BITS-1:0] new_val;
    ics_pkg::t_cell_ctl    ctl;

    logic [MAX_ITEMS-1:0]  occ;
    logic [MAX_ITEMS-1:0]  gt;
    logic [MAX_ITEMS-1:0]  bnd;
    logic [VALUE_BITS-1:0] val [MAX_ITEMS];

    logic [PW-1:0] pos;
    logic [FW-1:0] greater;
    logic [SW-1:0] sum;
    logic [63:0]   out_ext;

    assign o_s_axis_tready = (r_state == ST_FILL);
    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_xfer = o_m_axis_tvalid && i_m_axis_tready;
    assign full     = (r_fill == FW'(MAX_ITEMS));
    assign do_ins   = in_xfer && !full;

    assign in_ext  = 64'($signed(i_s_axis_tdata));
    assign new_val = in_ext[VALUE_BITS-1:0];

    assign ctl.ins   = do_ins;
    assign ctl.shift = out_xfer;

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        assign occ[g] = (r_fill > FW'(g));
        ics_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_new       (new_val),
            .i_occ       (occ[g]),
            .i_left_gt   ((g == 0) ? 1'b0 : gt[(g == 0) ? 0 : g - 1]),
            .i_left_val  (val[(g == 0) ? 0 : g - 1]),
            .i_right_val (val[(g == MAX_ITEMS - 1) ? g : g + 1]),
            .o_gt        (gt[g]),
            .o_bnd       (bnd[g]),
            .o_val       (val[g])
        );
    end

    // insertion point back to an index; greater = stored values above it
    always_comb begin
        pos = '0;
        for (int i = 0; i < MAX_ITEMS; i++) begin
            if (r_bnd[i]) begin
                pos = pos | PW'(i);
            end
        end
    end

    assign greater = r_fill_at - FW'(pos);
    assign sum     = SW'(r_total) + SW'(greater);

    assign out_ext         = 64'($signed(val[0]));
    assign o_m_axis_tvalid = (r_state == ST_DRAIN);
    assign o_m_axis_tdata  = {{PAD{1'b0}}, r_total, out_ext[DB-1:0]};
    assign o_m_axis_tuser  = r_drop;
    assign o_m_axis_tlast  = (r_fill == FW'(1));

    always_ff @(posedge i_clk) begin
        if (do_ins) begin
            r_bnd     <= bnd;
            r_fill_at <= r_fill;
        end
        if (!i_rst_n) begin
            r_state   <= ST_FILL;
            r_fill    <= '0;
            r_total   <= '0;
            r_drop    <= 1'b0;
            r_add_vld <= 1'b0;
        end else begin
            r_add_vld <= do_ins;
            if (r_add_vld) begin
                r_total <= (sum > SW'({IB{1'b1}})) ? {IB{1'b1}} : sum[IB-1:0];
            end
            unique case (r_state)
                ST_FILL: begin
                    if (in_xfer) begin
                        if (full) begin
                            r_drop <= 1'b1;
                        end else begin
                            r_fill <= r_fill + FW'(1);
                        end
                        if (i_s_axis_tlast) begin
                            r_state <= ST_SUM;
                        end
                    end
                end
                ST_SUM: begin
                    r_state <= ST_DRAIN;
                end
                ST_DRAIN: begin
                    if (out_xfer) begin
                        r_fill <= r_fill - FW'(1);
                        if (r_fill == FW'(1)) begin
                            r_total <= '0;
                            r_drop  <= 1'b0;
                            r_state <= ST_FILL;
                        end
                    end
                end
                default: begin
                    r_state <= ST_FILL;
                end
            endcase
        end
    end

endmodule

// ===== src/ics_cell.sv =====
// ---------------------------------------------------------------------------
// ics_cell: one slot of the insertion chain
// Holds one value, compares it with the incoming value and either keeps it,
// takes the new value, takes the left neighbor's value, or takes the right
// neighbor's value while the list drains.
// ---------------------------------------------------------------------------
module ics_cell #(
    parameter int VALUE_BITS = ics_pkg::DEF_VALUE_BITS
) (
    input  logic                  i_clk,
    input  ics_pkg::t_cell_ctl    i_ctl,
    input  logic [VALUE_BITS-1:0] i_new,
    input  logic                  i_occ,
    input  logic                  i_left_gt,
    input  logic [VALUE_BITS-1:0] i_left_val,
    input  logic [VALUE_BITS-1:0] i_right_val,
    output logic                  o_gt,
    output logic                  o_bnd,
    output logic [VALUE_BITS-1:0] o_val
);

    logic [VALUE_BITS-1:0] r_val;
    logic [VALUE_BITS-1:0] n_val;

    // empty slots count as greater so the insertion point always exists
    assign o_gt  = !i_occ || ($signed(r_val) > $signed(i_new));
    assign o_bnd = o_gt && !i_left_gt;
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.shift) begin
            n_val = i_right_val;
        end else if (i_ctl.ins) begin
            if (i_left_gt) begin
                n_val = i_left_val;
            end else if (o_gt) begin
                n_val = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// ===== bench/tb_inversion_count_sorter.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_inversion_count_sorter: self-checking bench of the inversion count sorter
// Streams lists of signed values, predicts each sorted list with its inversion
// total and dropped flag, and compares every output transfer in order.
// ---------------------------------------------------------------------------
module tb_inversion_count_sorter;

    localparam int DATA_BITS      = ics_pkg::DATA_BITS;
    localparam int INV_BITS       = ics_pkg::INV_BITS;
    localparam int IN_TDATA_BITS  = ics_pkg::IN_TDATA_BITS;
    localparam int OUT_TDATA_BITS = ics_pkg::OUT_TDATA_BITS;

    localparam int CAPACITY    = ics_pkg::DEF_MAX_ITEMS;
    localparam int INV_LIMIT   = (1 << INV_BITS) - 1;
    localparam int RANDOM_GOAL = 64;
    localparam int DRAIN_TAIL  = 40;
    localparam int REPORT_MAX  = 10;

    typedef enum int {
        MIX_WIDE,
        MIX_NARROW,
        MIX_EDGE
    } t_value_mix;

    typedef struct packed {
        logic signed [DATA_BITS-1:0] value;
        logic [INV_BITS-1:0]         inversions;
        logic                        dropped;
        logic                        final_res;
    } t_sorted_result;

    // keeps its own sorted copy of the list and the results owed for it
    class sort_ledger;
        logic signed [DATA_BITS-1:0] held_values[$];
        t_sorted_result              owed_results[$];
        int                          inv_total;
        logic                        dropped_flag;
        int                          mismatches;

        function new();
            inv_total    = 0;
            dropped_flag = 1'b0;
            mismatches   = 0;
        endfunction

        function void take_value(logic signed [DATA_BITS-1:0] v, logic last);
            int greater;
            int slot;
            t_sorted_result r;
            if (held_values.size() < CAPACITY) begin
                greater = 0;
                slot    = held_values.size();
                foreach (held_values[i]) begin
                    if (held_values[i] > v) begin
                        greater++;
                        if (slot == held_values.size()) slot = i;
                    end
                end
                if (inv_total + greater > INV_LIMIT) inv_total = INV_LIMIT;
                else inv_total += greater;
                held_values.insert(slot, v);
            end else begin
                dropped_flag = 1'b1;
            end
            if (last) begin
                foreach (held_values[i]) begin
                    r.value      = held_values[i];
                    r.inversions = inv_total[INV_BITS-1:0];
                    r.dropped    = dropped_flag;
                    r.final_res  = (i == held_values.size() - 1);
                    owed_results.push_back(r);
                end
                held_values.delete();
                inv_total    = 0;
                dropped_flag = 1'b0;
            end
        endfunction

        function void match_result(t_sorted_result got);
            t_sorted_result want;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected transfer: value %0d inv %0d dropped %0b last %0b",
                             got.value, got.inversions, got.dropped, got.final_res);
                return;
            end
            want = owed_results.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display({"mismatch: expected value %0d inv %0d dropped %0b last %0b,",
                              " got value %0d inv %0d dropped %0b last %0b"},
                             want.value, want.inversions, want.dropped, want.final_res,
                             got.value, got.inversions, got.dropped, got.final_res);
            end
        endfunction

        function int outstanding();
            return owed_results.size();
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      s_valid;
    logic                      s_ready;
    logic [IN_TDATA_BITS-1:0]  s_data;
    logic                      s_last;
    logic                      m_valid;
    logic                      m_ready;
    logic [OUT_TDATA_BITS-1:0] m_data;
    logic                      m_user;
    logic                      m_last;

    // while set, neither side idles
    logic       quiet;
    sort_ledger ledger;

    inversion_count_sorter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // value[31:0]
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // value[31:0], inversions[40:32]
        .o_m_axis_tuser  (m_user),   // dropped
        .o_m_axis_tlast  (m_last)
    );

    always #5 i_clk = ~i_clk;

    // receiver stalls now and then
    always @(negedge i_clk) begin
        if (!quiet && $urandom_range(99) < 7) m_ready <= 1'b0;
        else m_ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        t_sorted_result got;
        if (i_rst_n && m_valid && m_ready) begin
            got.value      = m_data[DATA_BITS-1:0];
            got.inversions = m_data[DATA_BITS +: INV_BITS];
            got.dropped    = m_user;
            got.final_res  = m_last;
            ledger.match_result(got);
        end
    end

    function automatic logic [DATA_BITS-1:0] pick_value(t_value_mix mix);
        case (mix)
            MIX_WIDE:   return $urandom;
            MIX_NARROW: return DATA_BITS'(int'($urandom_range(6)) - 3);
            default: begin
                case ($urandom_range(3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
        endcase
    endfunction

    task automatic send_value(input logic [DATA_BITS-1:0] val, input logic last);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 7) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= val;
        s_last  <= last;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        ledger.take_value(val, last);
    endtask

    task automatic send_list(input int len, input t_value_mix mix);
        for (int i = 0; i < len; i++) send_value(pick_value(mix), i == len - 1);
    endtask

    initial begin
        int sent;
        int len;
        t_value_mix mix;

        ledger  = new();
        i_clk   = 1'b0;
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        s_last  = 1'b0;
        m_ready = 1'b0;
        quiet   = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single element list at the negative extreme
        send_value(32'h8000_0000, 1'b1);
        // extremes mixed, repeated max must keep arrival order
        send_value(32'h7fff_ffff, 1'b0);
        send_value(32'h0000_0000, 1'b0);
        send_value(32'hffff_ffff, 1'b0);
        send_value(32'h8000_0000, 1'b0);
        send_value(32'h7fff_ffff, 1'b0);
        send_value(32'h0000_0007, 1'b1);
        // equal values are not inversions
        send_value(32'd3, 1'b0);
        send_value(32'd3, 1'b0);
        send_value(32'hffff_ffff, 1'b0);
        send_value(32'd3, 1'b1);
        // strictly descending full store, then two values past capacity,
        // the final one among the discarded
        for (int i = 0; i < CAPACITY; i++)
            send_value(DATA_BITS'(CAPACITY - i) * 32'h0200_0001, 1'b0);
        send_value(32'h1234_5678, 1'b0);
        send_value(32'h8765_4321, 1'b1);

        sent = 0;
        while (sent < RANDOM_GOAL) begin
            quiet = (sent >= 15 && sent < 45);
            if ($urandom_range(9) == 0) len = $urandom_range(CAPACITY + 2, CAPACITY - 2);
            else len = $urandom_range(12, 1);
            case ($urandom_range(9))
                0, 1, 2, 3, 4: mix = MIX_WIDE;
                5, 6, 7:       mix = MIX_NARROW;
                default:       mix = MIX_EDGE;
            endcase
            send_list(len, mix);
            sent += len;
        end
        quiet = 1'b0;

        @(negedge i_clk);
        s_valid <= 1'b0;
        while (ledger.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);

        if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
            $display("tb_inversion_count_sorter OK");
        end else begin
            $display("tb_inversion_count_sorter NOT OK");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_inversion_count_sorter NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/ics_pkg.sv
src/ics_cell.sv
src/inversion_count_sorter.sv
bench/tb_inversion_count_sorter.sv
